/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the notch biquad cascade.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MNBC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define MNBC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define MNBC_ASSERT(lbl, clk, rst_n, prop)
`define MNBC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hdl/mnbc_pkg.sv */
// Types and constants of the multichannel notch biquad cascade.
package mnbc_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int ACC_W       = 68;
	localparam int CFG_W       = 5;

	localparam logic       CMD_LOAD   = 1'b0;
	localparam logic       CMD_FILTER = 1'b1;

	localparam logic [1:0] SEL_B0 = 2'd0;
	localparam logic [1:0] SEL_B1 = 2'd1;
	localparam logic [1:0] SEL_A2 = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_STALE  = 2'd1;
	localparam logic [1:0] ST_SAT    = 2'd2;
	localparam logic [1:0] ST_LOADED = 2'd3;

	localparam logic CFG_STAGE_COUNT   = 1'b0;
	localparam logic CFG_CHANNEL_COUNT = 1'b1;

	// MAC phases: products 0..4, phase 5 only drains the last product
	localparam logic [2:0] PH_B0X  = 3'd0;
	localparam logic [2:0] PH_B1H0 = 3'd1;
	localparam logic [2:0] PH_B0H1 = 3'd2;
	localparam logic [2:0] PH_B1H2 = 3'd3;
	localparam logic [2:0] PH_A2H3 = 3'd4;
	localparam logic [2:0] PH_LAST = 3'd5;

	typedef struct packed {
		logic               command;
		logic signed [23:0] sample_in;
		logic [15:0]        source_tag;
		logic [31:0]        epoch;
		logic [3:0]         coef_stage;
		logic [1:0]         coef_select;
		logic signed [31:0] coef_value;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] sample_out;
		logic [2:0]         channel_index;
		logic [1:0]         status;
		logic               src_reset;
		logic               ep_reset;
	} out_item_t;

	typedef struct packed {
		logic       take;
		logic       eval;
		logic       read;
		logic       mac;
		logic [2:0] phase;
		logic       fin;
		logic       last;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic stale;
		logic out_free;
	} sts_t;

endpackage

/* hdl/mnbc_ctrl.sv */
// Sequencer: walks one item through decode, per-stage read, MAC and writeback.
module mnbc_ctrl
	import mnbc_pkg::*;
#(
	parameter int ST_W = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  sts_t            sts,
	input  logic [ST_W:0]   stage_num,
	output logic [ST_W-1:0] stage,
	output cmd_t            cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EVAL = 6'b000010,
		S_READ = 6'b000100,
		S_MAC  = 6'b001000,
		S_FIN  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t          state_q;
	logic [ST_W-1:0] stage_q;
	logic [2:0]      phase_q;
	logic            last;

	assign last     = ((ST_W+1)'(stage_q) + (ST_W+1)'(1)) == stage_num;
	assign in_stall = (state_q != S_IDLE);
	assign stage    = stage_q;

	// command decode
	always_comb begin
		cmd       = '0;
		cmd.take  = (state_q == S_IDLE) && in_valid;
		cmd.eval  = (state_q == S_EVAL);
		cmd.read  = (state_q == S_READ);
		cmd.mac   = (state_q == S_MAC);
		cmd.phase = phase_q;
		cmd.fin   = (state_q == S_FIN);
		cmd.last  = last;
		cmd.emit  = (state_q == S_OUT) && sts.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stage_q <= '0;
			phase_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EVAL;
				end
				S_EVAL: begin
					stage_q <= '0;
					if (sts.is_load || sts.stale) state_q <= S_OUT;
					else state_q <= S_READ;
				end
				S_READ: begin
					phase_q <= PH_B0X;
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (phase_q == PH_LAST) state_q <= S_FIN;
					else phase_q <= phase_q + 3'd1;
				end
				S_FIN: begin
					if (last) begin
						state_q <= S_OUT;
					end else begin
						stage_q <= stage_q + ST_W'(1);
						state_q <= S_READ;
					end
				end
				S_OUT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hdl/mnbc_datapath.sv */
// Datapath: config, coefficient and history stores, shared MAC, output register.
module mnbc_datapath
	import mnbc_pkg::*;
#(
	parameter int MAX_STAGES     = 16,
	parameter int MAX_CHANNELS   = 8,
	parameter int COEF_FRAC_BITS = 30,
	parameter int ST_W           = 4,
	parameter int CH_W           = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         in_data,
	input  logic             out_stall,
	output logic             out_valid,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  cmd_t             cmd,
	input  logic [ST_W-1:0]  stage,
	output logic [ST_W:0]    stage_num,
	output sts_t             sts
);

	localparam int ROWS = MAX_CHANNELS * MAX_STAGES;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SB = SAMPLE_BITS;
	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

	// configuration registers
	logic [4:0] stage_cnt_q;
	logic [3:0] chan_cnt_q;
	logic [CH_W:0] chans;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_cnt_q <= 5'd1;
			chan_cnt_q  <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STAGE_COUNT:   stage_cnt_q <= cfg_data[4:0];
				CFG_CHANNEL_COUNT: chan_cnt_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamp counts into 1..max
	always_comb begin
		if (stage_cnt_q == 5'd0) stage_num = (ST_W+1)'(1);
		else if (32'(stage_cnt_q) > MAX_STAGES) stage_num = (ST_W+1)'(MAX_STAGES);
		else stage_num = (ST_W+1)'(stage_cnt_q);
		if (chan_cnt_q == 4'd0) chans = (CH_W+1)'(1);
		else if (32'(chan_cnt_q) > MAX_CHANNELS) chans = (CH_W+1)'(MAX_CHANNELS);
		else chans = (CH_W+1)'(chan_cnt_q);
	end

	// input capture
	in_item_t in_q;
	always_ff @(posedge clk) begin
		if (cmd.take) in_q <= in_data;
	end

	// stream tracking
	logic            active_q;
	logic [15:0]     src_q;
	logic [31:0]     ep_q;
	logic [CH_W-1:0] ptr_q;
	logic [CH_W-1:0] ptr_fix;
	logic            src_chg, ep_chg, clear;

	assign ptr_fix = ((CH_W+1)'(ptr_q) >= chans) ? '0 : ptr_q;
	assign src_chg = active_q && (in_q.source_tag != src_q);
	assign ep_chg  = active_q && !src_chg && (in_q.epoch > ep_q);
	assign clear   = src_chg || ep_chg;

	assign sts.is_load = (in_q.command == CMD_LOAD);
	assign sts.stale   = active_q && !src_chg && (in_q.epoch < ep_q);

	// coefficient stores, one per word kind
	logic signed [31:0] b0_mem [MAX_STAGES];
	logic signed [31:0] b1_mem [MAX_STAGES];
	logic signed [31:0] a2_mem [MAX_STAGES];
	logic signed [31:0] b0_q, b1_q, a2_q;
	logic               coef_ok;

	assign coef_ok = (32'(in_q.coef_stage) < MAX_STAGES);

	always_ff @(posedge clk) begin
		if (cmd.eval && sts.is_load && coef_ok) begin
			case (in_q.coef_select)
				SEL_B0: b0_mem[ST_W'(in_q.coef_stage)] <= in_q.coef_value;
				SEL_B1: b1_mem[ST_W'(in_q.coef_stage)] <= in_q.coef_value;
				SEL_A2: a2_mem[ST_W'(in_q.coef_stage)] <= in_q.coef_value;
				default: ;
			endcase
		end
		if (cmd.read) begin
			b0_q <= b0_mem[stage];
			b1_q <= b1_mem[stage];
			a2_q <= a2_mem[stage];
		end
	end

	// history store: one row {y2, y1, x2, x1} per channel and stage
	logic [127:0]    hist_mem [ROWS];
	logic [127:0]    hist_rd_q;
	logic [ROWS-1:0] hist_vld_q;
	logic            vld_rd_q;
	logic [CH_W-1:0] ch_q;
	logic [ROW_W-1:0] row;
	logic signed [31:0] h0, h1, h2, h3;

	assign row = ROW_W'(int'(ch_q) * MAX_STAGES + int'(stage));
	assign h0 = vld_rd_q ? hist_rd_q[31:0]   : '0;
	assign h1 = vld_rd_q ? hist_rd_q[63:32]  : '0;
	assign h2 = vld_rd_q ? hist_rd_q[95:64]  : '0;
	assign h3 = vld_rd_q ? hist_rd_q[127:96] : '0;

	// shared multiplier with registered product
	logic signed [31:0]      x_q;
	logic signed [31:0]      op_a, op_b;
	logic signed [63:0]      prod_s1;
	logic signed [ACC_W-1:0] acc_q;

	always_comb begin
		case (cmd.phase)
			PH_B0X:  begin op_a = b0_q; op_b = x_q; end
			PH_B1H0: begin op_a = b1_q; op_b = h0;  end
			PH_B0H1: begin op_a = b0_q; op_b = h1;  end
			PH_B1H2: begin op_a = b1_q; op_b = h2;  end
			default: begin op_a = a2_q; op_b = h3;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mac) begin
			prod_s1 <= op_a * op_b;
			case (cmd.phase)
				PH_B0X: acc_q <= RND;
				PH_B1H0, PH_B0H1, PH_B1H2: acc_q <= acc_q + ACC_W'(prod_s1);
				default: acc_q <= acc_q - ACC_W'(prod_s1);
			endcase
		end
	end

	// stage writeback: scale, saturate to 32 and to sample width
	logic signed [ACC_W-1:0] shifted;
	logic signed [31:0]      y;
	logic                    sat32;
	logic signed [SB-1:0]    y_out;
	logic                    sat_out;

	assign shifted = acc_q >>> COEF_FRAC_BITS;
	assign sat32   = shifted[ACC_W-1:31] != {(ACC_W-31){shifted[31]}};
	assign y       = !sat32 ? shifted[31:0] :
		(shifted[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff);
	assign sat_out = y[31:SB-1] != {(33-SB){y[31]}};
	assign y_out   = !sat_out ? y[SB-1:0] :
		(y[31] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});

	logic            sat_q, src_chg_q, ep_chg_q;
	out_item_t       res_q;
	out_item_t       res_eval;
	logic [CH_W-1:0] ch_next;

	assign ch_next = ((CH_W+1)'(ch_q) + (CH_W+1)'(1) >= chans) ? '0 : ch_q + CH_W'(1);

	// result of an item that ends at decode: load or stale epoch
	always_comb begin
		res_eval = '0;
		if (sts.is_load) res_eval.status = ST_LOADED;
		else if (sts.stale) begin
			res_eval.status        = ST_STALE;
			res_eval.channel_index = 3'(ptr_fix);
		end
	end

	// history memory port
	always_ff @(posedge clk) begin
		if (cmd.read) hist_rd_q <= hist_mem[row];
		if (cmd.fin) hist_mem[row] <= {h2, y, h0, x_q};
	end

	// valid bits and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			vld_rd_q   <= 1'b0;
			active_q   <= 1'b0;
			src_q      <= '0;
			ep_q       <= '0;
			ptr_q      <= '0;
		end else begin
			if (cmd.read) vld_rd_q <= hist_vld_q[row];
			// a stale sample never clears, so clear alone decides the reset
			if (cmd.eval && !sts.is_load) begin
				ptr_q <= clear ? '0 : ptr_fix;
				if (clear) hist_vld_q <= '0;
			end
			if (cmd.fin) begin
				hist_vld_q[row] <= 1'b1;
				if (cmd.last) begin
					active_q <= 1'b1;
					src_q    <= in_q.source_tag;
					ep_q     <= in_q.epoch;
					ptr_q    <= ch_next;
				end
			end
		end
	end

	// per-item working registers and result staging
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			x_q       <= 32'(in_q.sample_in);
			sat_q     <= 1'b0;
			src_chg_q <= src_chg;
			ep_chg_q  <= ep_chg;
			ch_q      <= clear ? '0 : ptr_fix;
			res_q     <= res_eval;
		end
		if (cmd.fin) begin
			x_q   <= y;
			sat_q <= sat_q | sat32;
			if (cmd.last) begin
				res_q <= '{
					sample_out:    y_out,
					channel_index: 3'(ch_q),
					status:        (sat_q || sat32 || sat_out) ? ST_SAT : ST_OK,
					src_reset:     src_chg_q,
					ep_reset:      ep_chg_q
				};
			end
		end
	end

	// output register
	logic out_vld_q;
	assign sts.out_free = !out_vld_q || !out_stall;
	assign out_valid    = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (cmd.emit) out_vld_q <= 1'b1;
		else if (!out_stall) out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_data <= res_q;
	end

endmodule

/* hdl/multichannel_notch_biquad_cascade_core.sv */
// Top level of the multichannel notch biquad cascade: sequencer plus datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | in_data  (in_item_t)
//  out     | output    | out_valid / out_stall| out_data (out_item_t)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A filter sample runs, for each of S active stages, one read, the MAC phases on
// the single shared multiplier and one writeback; a load goes from decode to output.
// One item is in work at a time; the next one is taken while a result waits.
// Reset clears history valid bits at once; no clearing pass is needed.
// A stalled output holds the finished item until out_stall drops; the next one waits.
`include "assert_macros.svh"
module multichannel_notch_biquad_cascade_core
	import mnbc_pkg::*;
#(
	parameter int MAX_STAGES     = 16,
	parameter int MAX_CHANNELS   = 8,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int ST_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	cmd_t            cmd;
	sts_t            sts;
	logic [ST_W-1:0] stage;
	logic [ST_W:0]   stage_num;

	mnbc_ctrl #(
		.ST_W(ST_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sts       (sts),
		.stage_num (stage_num),
		.stage     (stage),
		.cmd       (cmd)
	);

	mnbc_datapath #(
		.MAX_STAGES     (MAX_STAGES),
		.MAX_CHANNELS   (MAX_CHANNELS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.ST_W           (ST_W),
		.CH_W           (CH_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stage     (stage),
		.stage_num (stage_num),
		.sts       (sts)
	);

	// checks
	`MNBC_ASSERT(a_take_eval, clk, arst_n, (in_valid && !in_stall) |=> cmd.eval)
	`MNBC_ASSERT(a_emit_free, clk, arst_n, cmd.emit |-> sts.out_free)
	`MNBC_ASSERT(a_out_rise, clk, arst_n, $rose(out_valid) |-> $past(cmd.emit))
	`MNBC_NEVER(a_idle_quiet, clk, arst_n, !in_stall && (cmd.read || cmd.mac || cmd.fin))

endmodule
